// ===== hdl/dual_lcd_display_ram_writer_assert.svh =====
// ---------------------------------------------------------------------------
// dual lcd display ram writer assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ---------------------------------------------------------------------------
`ifndef DUAL_LCD_DISPLAY_RAM_WRITER_ASSERT_SVH
`define DUAL_LCD_DISPLAY_RAM_WRITER_ASSERT_SVH

// condition holds at every edge
`define DLCD_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("dlcd assertion failed");

// consequent holds in the same cycle
`define DLCD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dlcd assertion failed");

// consequent holds in the next cycle
`define DLCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dlcd assertion failed");

`endif

// ===== hdl/dlcd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dlcd_pkg
// geometry, codes and item types shared by the display ram writer
// ---------------------------------------------------------------------------
package dlcd_pkg;

  localparam int WIDTH = 240;
  localparam int HALF  = 120;
  localparam int PAGES = 12;

  localparam int DEPTH  = WIDTH * PAGES;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam int LCOL_W = 7;
  localparam int RCOL_W = 8;
  localparam int COL_W  = 8;
  localparam int PAGE_W = 4;
  localparam int BYTE_W = 8;

  localparam logic [3:0] SET_PAGE_CODE = 4'hB;

  localparam logic CMD_INSTR  = 1'b0;
  localparam logic CMD_DATA   = 1'b1;
  localparam logic CHIP_LEFT  = 1'b0;
  localparam logic CHIP_RIGHT = 1'b1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int OUT_BITS    = COL_W + PAGE_W + BYTE_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [COL_W-1:0]  column;
    logic [PAGE_W-1:0] page;
    logic [BYTE_W-1:0] pixels;
  } op_t;

  typedef struct packed {
    logic [BYTE_W-1:0] pixels;
    logic [PAGE_W-1:0] page;
    logic [COL_W-1:0]  column;
  } result_t;

endpackage

// ===== hdl/dual_lcd_display_ram_writer.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dual_lcd_display_ram_writer
// two-chip page/column graphic lcd display ram with draw events
// ---------------------------------------------------------------------------
// After reset the display ram is cleared one byte per cycle, 2880 bytes
// (WIDTH * PAGES), with s_axis_tready low. Then a bus write is taken
// whenever the queue is not full: page instructions, other instructions
// and ignored data writes finish on acceptance, and data writes go into a
// two-entry queue. The display ram has one write port and a registered
// read, so each queued data write is read, then compared and written back
// before the next is read, and a read also waits for a free output register.
// A changed byte leaves as one draw item (column, page, pixels) through it.

module dual_lcd_display_ram_writer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // bus_byte
  input  logic [1:0]                         s_axis_tuser,  // chip, cmd
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [dlcd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata   // column, page, pixels, zero pad
);

  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_empty;
  logic              clearing;
  dlcd_pkg::op_t     front_op;
  dlcd_pkg::op_t     q_op;
  dlcd_pkg::result_t result;

  dlcd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .chip_i     (s_axis_tuser[0]),
    .cmd_i      (s_axis_tuser[1]),
    .bus_byte_i (s_axis_tdata),
    .clearing_i (clearing),
    .q_full_i   (q_full),
    .push_o     (push),
    .op_o       (front_op)
  );

  dlcd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (front_op),
    .full_o  (q_full),
    .pop_i   (pop),
    .op_o    (q_op),
    .empty_o (q_empty)
  );

  dlcd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_op_i     (q_op),
    .pop_o      (pop),
    .clearing_o (clearing),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_result_o (result)
  );

  assign m_axis_tdata = {{(dlcd_pkg::OUT_TDATA_W - dlcd_pkg::OUT_BITS){1'b0}}, result};

endmodule

// ===== hdl/dlcd_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dlcd_front
// accepts bus writes, tracks page and column per chip, queues ram writes
// ---------------------------------------------------------------------------
`include "dual_lcd_display_ram_writer_assert.svh"

module dlcd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  output logic            s_ready_o,
  input  logic            chip_i,
  input  logic            cmd_i,
  input  logic [dlcd_pkg::BYTE_W-1:0] bus_byte_i,
  input  logic            clearing_i,
  input  logic            q_full_i,
  output logic            push_o,
  output dlcd_pkg::op_t   op_o
);

  logic [dlcd_pkg::LCOL_W-1:0] left_col_q, left_col_d;
  logic [dlcd_pkg::RCOL_W-1:0] right_col_q, right_col_d;
  logic [dlcd_pkg::PAGE_W-1:0] left_page_q, left_page_d;
  logic [dlcd_pkg::PAGE_W-1:0] right_page_q, right_page_d;

  logic                        accept;
  logic                        set_page;
  logic                        in_range;
  logic [dlcd_pkg::COL_W-1:0]  cur_col;
  logic [dlcd_pkg::COL_W-1:0]  limit;
  logic [dlcd_pkg::PAGE_W-1:0] cur_page;

  assign s_ready_o = !clearing_i && !q_full_i;
  assign accept    = s_valid_i && s_ready_o;
  assign set_page  = (cmd_i == dlcd_pkg::CMD_INSTR) &&
                     (bus_byte_i[7:4] == dlcd_pkg::SET_PAGE_CODE);

  assign cur_col  = (chip_i == dlcd_pkg::CHIP_RIGHT) ? right_col_q
                                                     : dlcd_pkg::COL_W'(left_col_q);
  assign cur_page = (chip_i == dlcd_pkg::CHIP_RIGHT) ? right_page_q : left_page_q;
  assign limit    = (chip_i == dlcd_pkg::CHIP_RIGHT) ? dlcd_pkg::COL_W'(dlcd_pkg::WIDTH)
                                                     : dlcd_pkg::COL_W'(dlcd_pkg::HALF);

  assign in_range = (cur_col < limit) && (cur_col < dlcd_pkg::COL_W'(dlcd_pkg::WIDTH)) &&
                    ({1'b0, cur_page} < (dlcd_pkg::PAGE_W + 1)'(dlcd_pkg::PAGES));

  assign push_o = accept && (cmd_i == dlcd_pkg::CMD_DATA) && in_range;

  assign op_o.addr   = dlcd_pkg::ADDR_W'(cur_col) * dlcd_pkg::ADDR_W'(dlcd_pkg::PAGES)
                       + dlcd_pkg::ADDR_W'(cur_page);
  assign op_o.column = cur_col;
  assign op_o.page   = cur_page;
  assign op_o.pixels = bus_byte_i;

  always_comb begin
    left_col_d   = left_col_q;
    right_col_d  = right_col_q;
    left_page_d  = left_page_q;
    right_page_d = right_page_q;
    if (accept && set_page) begin
      if (chip_i == dlcd_pkg::CHIP_RIGHT) begin
        right_page_d = bus_byte_i[3:0];
        right_col_d  = dlcd_pkg::RCOL_W'(dlcd_pkg::HALF);
      end else begin
        left_page_d = bus_byte_i[3:0];
        left_col_d  = '0;
      end
    end else if (push_o) begin
      if (chip_i == dlcd_pkg::CHIP_RIGHT) begin
        right_col_d = right_col_q + 1'b1;
      end else begin
        left_col_d = left_col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_col_q   <= '0;
      right_col_q  <= dlcd_pkg::RCOL_W'(dlcd_pkg::HALF);
      left_page_q  <= '0;
      right_page_q <= '0;
    end else begin
      left_col_q   <= left_col_d;
      right_col_q  <= right_col_d;
      left_page_q  <= left_page_d;
      right_page_q <= right_page_d;
    end
  end

  `DLCD_ASSERT_ALWAYS(a_left_col_in_half, left_col_q <= dlcd_pkg::LCOL_W'(dlcd_pkg::HALF))
  `DLCD_ASSERT_ALWAYS(a_right_col_in_half, right_col_q >= dlcd_pkg::RCOL_W'(dlcd_pkg::HALF))

endmodule

// ===== hdl/dlcd_fifo.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dlcd_fifo
// short queue of pending ram writes between front and back
// ---------------------------------------------------------------------------
`include "dual_lcd_display_ram_writer_assert.svh"

module dlcd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dlcd_pkg::op_t op_i,
  output logic          full_o,
  input  logic          pop_i,
  output dlcd_pkg::op_t op_o,
  output logic          empty_o
);

  dlcd_pkg::op_t entries_q [dlcd_pkg::QDEPTH];

  logic [dlcd_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [dlcd_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [dlcd_pkg::QCNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == dlcd_pkg::QCNT_W'(dlcd_pkg::QDEPTH));
  assign empty_o = (count_q == '0);
  assign op_o    = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == dlcd_pkg::QPTR_W'(dlcd_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == dlcd_pkg::QPTR_W'(dlcd_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= op_i;
    end
  end

  `DLCD_ASSERT_ALWAYS(a_count_bound, count_q <= dlcd_pkg::QCNT_W'(dlcd_pkg::QDEPTH))

endmodule

// ===== hdl/dlcd_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dlcd_back
// display ram: clear after reset, read, compare and write back, emit draws
// ---------------------------------------------------------------------------
`include "dual_lcd_display_ram_writer_assert.svh"

module dlcd_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  input  dlcd_pkg::op_t         q_op_i,
  output logic                  pop_o,
  output logic                  clearing_o,
  output logic                  m_valid_o,
  input  logic                  m_ready_i,
  output dlcd_pkg::result_t     m_result_o
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_CMP
  } state_e;

  logic [dlcd_pkg::BYTE_W-1:0] mem [dlcd_pkg::DEPTH];

  state_e                      state_q;
  logic [dlcd_pkg::ADDR_W-1:0] clr_cnt_q;
  logic                        m_valid_q;
  dlcd_pkg::result_t           result_q;
  dlcd_pkg::op_t               op_q;
  logic [dlcd_pkg::BYTE_W-1:0] rd_q;

  logic                        changed;
  logic                        mem_we;
  logic [dlcd_pkg::ADDR_W-1:0] mem_waddr;
  logic [dlcd_pkg::BYTE_W-1:0] mem_wdata;

  assign pop_o      = (state_q == S_IDLE) && !q_empty_i && (!m_valid_q || m_ready_i);
  assign changed    = (rd_q != op_q.pixels);
  assign mem_we     = (state_q == S_CLEAR) || ((state_q == S_CMP) && changed);
  assign mem_waddr  = (state_q == S_CLEAR) ? clr_cnt_q : op_q.addr;
  assign mem_wdata  = (state_q == S_CLEAR) ? '0 : op_q.pixels;
  assign clearing_o = (state_q == S_CLEAR);
  assign m_valid_o  = m_valid_q;
  assign m_result_o = result_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (pop_o) begin
      rd_q <= mem[q_op_i.addr];
      op_q <= q_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_cnt_q <= '0;
      m_valid_q <= 1'b0;
      result_q  <= '0;
    end else begin
      if (m_valid_q && m_ready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == dlcd_pkg::ADDR_W'(dlcd_pkg::DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop_o) begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          state_q <= S_IDLE;
          if (changed) begin
            m_valid_q       <= 1'b1;
            result_q.column <= op_q.column;
            result_q.page   <= op_q.page;
            result_q.pixels <= op_q.pixels;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `DLCD_ASSERT_NEXT(a_draw_carries_new_byte, (state_q == S_CMP) && changed, m_valid_q && (result_q.pixels == $past(op_q.pixels)))
  `DLCD_ASSERT_IMPL(a_draw_from_compare, $rose(m_valid_q), $past(state_q == S_CMP))

endmodule

// ===== sim/dual_lcd_display_ram_writer_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dual_lcd_display_ram_writer_tb
// Checks every draw item against a shadow copy of both chips' column/page
// state and the display ram. A short directed run covers page setting,
// ignored instructions, pages out of range and unchanged bytes. Random
// page-then-data bursts follow, some past the end of a half, with random
// stalls on both sides, one long output hold-off and pauses to drain the block.
// ---------------------------------------------------------------------------
module dual_lcd_display_ram_writer_tb;
  import dlcd_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int IDLE_PCT     = 38;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 20;

  typedef struct packed {
    logic              chip;
    logic              cmd;
    logic [BYTE_W-1:0] bus_byte;
  } bus_write_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata  = '0;  // bus_byte
  logic [1:0]             s_axis_tuser  = '0;  // chip, cmd
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // column, page, pixels, zero pad

  bus_write_t bus_writes[$];
  result_t    draws_due[$];

  logic [LCOL_W-1:0] left_col;
  logic [RCOL_W-1:0] right_col;
  logic [PAGE_W-1:0] left_page;
  logic [PAGE_W-1:0] right_page;
  logic [BYTE_W-1:0] shadow_ram [DEPTH];

  int errors        = 0;
  int cycles        = 0;
  int send_idle_pct = IDLE_PCT;
  int recv_idle_pct = IDLE_PCT;
  int hold_asked    = 0;
  int hold_done     = 0;
  int hold_left     = 0;

  dual_lcd_display_ram_writer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow of one accepted bus write, queues the draw item it causes
  task automatic apply_bus_write(input logic chip, input logic cmd,
                                 input logic [BYTE_W-1:0] bus_byte);
    logic [COL_W-1:0]  col;
    logic [PAGE_W-1:0] pg;
    int                lim;
    int                idx;
    result_t           draw;
    if (cmd == CMD_INSTR) begin
      if (bus_byte[7:4] == SET_PAGE_CODE) begin
        if (chip == CHIP_LEFT) begin
          left_page = bus_byte[3:0];
          left_col  = '0;
        end else begin
          right_page = bus_byte[3:0];
          right_col  = RCOL_W'(HALF);
        end
      end
    end else begin
      if (chip == CHIP_LEFT) begin
        col = COL_W'(left_col);
        pg  = left_page;
        lim = HALF;
      end else begin
        col = right_col;
        pg  = right_page;
        lim = WIDTH;
      end
      if (int'(col) < lim && int'(col) < WIDTH && int'(pg) < PAGES) begin
        if (chip == CHIP_LEFT) left_col = left_col + 1'b1;
        else right_col = right_col + 1'b1;
        idx = int'(col) * PAGES + int'(pg);
        if (shadow_ram[idx] != bus_byte) begin
          shadow_ram[idx] = bus_byte;
          draw.column = col;
          draw.page   = pg;
          draw.pixels = bus_byte;
          draws_due.push_back(draw);
        end
      end
    end
  endtask

  task automatic check_field(input string what, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  task automatic push_write(input logic chip, input logic cmd,
                            input logic [BYTE_W-1:0] bus_byte);
    bus_write_t w;
    w.chip     = chip;
    w.cmd      = cmd;
    w.bus_byte = bus_byte;
    bus_writes.push_back(w);
  endtask

  function automatic logic [BYTE_W-1:0] pick_pixels();
    int r;
    r = $urandom_range(99);
    if (r < 45) return BYTE_W'($urandom_range(255));
    if (r < 65) return 8'h00;
    if (r < 80) return 8'hFF;
    return 8'h5A ^ {8{1'($urandom_range(1))}};
  endfunction

  function automatic logic [BYTE_W-1:0] other_instr();
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom_range(255));
    if (b[7:4] == SET_PAGE_CODE) b[7:4] = ~SET_PAGE_CODE;
    return b;
  endfunction

  // page set followed by a data burst, mixed with stray writes
  task automatic push_random(input int count);
    int                n;
    int                len;
    int                r;
    logic              side;
    logic [PAGE_W-1:0] pg;
    n = 0;
    while (n < count) begin
      if ($urandom_range(99) < 80) begin
        side = 1'($urandom_range(1));
        if ($urandom_range(99) < 85) pg = PAGE_W'($urandom_range(PAGES - 1));
        else pg = PAGE_W'($urandom_range(15, PAGES));
        push_write(side, CMD_INSTR, {SET_PAGE_CODE, pg});
        if ($urandom_range(99) < 6) len = $urandom_range(HALF + 10, HALF + 1);
        else len = $urandom_range(16, 1);
        n += len + 1;
        repeat (len) begin
          r = $urandom_range(99);
          if (r < 6) push_write(!side, CMD_DATA, pick_pixels());
          else if (r < 10) push_write(side, CMD_INSTR, other_instr());
          push_write(side, CMD_DATA, pick_pixels());
        end
      end else begin
        push_write(1'($urandom_range(1)), 1'($urandom_range(1)),
                   BYTE_W'($urandom_range(255)));
        n++;
      end
    end
  endtask

  task automatic drain();
    while (bus_writes.size() > 0 || s_axis_tvalid || draws_due.size() > 0)
      @(negedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive
    bus_write_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        apply_bus_write(s_axis_tuser[0], s_axis_tuser[1], s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (bus_writes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = bus_writes.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nxt.bus_byte;
          s_axis_tuser  <= {nxt.cmd, nxt.chip};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t got;
    result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[OUT_BITS-1:0]);
        if (draws_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected draw item, expected none, actual col %0d page %0d pixels %0d",
                   $time, got.column, got.page, got.pixels);
        end else begin
          want = draws_due.pop_front();
          check_field("column", want.column, got.column);
          check_field("page", 8'(want.page), 8'(got.page));
          check_field("pixels", want.pixels, got.pixels);
        end
      end
      if (hold_asked != hold_done) begin
        hold_done = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("dual_lcd_display_ram_writer_tb: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    left_col   = '0;
    right_col  = RCOL_W'(HALF);
    left_page  = '0;
    right_page = '0;
    foreach (shadow_ram[i]) shadow_ram[i] = '0;

    // unchanged byte on cleared ram, then changes on pages 0 and 3
    push_write(CHIP_LEFT, CMD_DATA, 8'h00);
    push_write(CHIP_LEFT, CMD_DATA, 8'hFF);
    push_write(CHIP_LEFT, CMD_INSTR, {SET_PAGE_CODE, 4'h3});
    push_write(CHIP_LEFT, CMD_DATA, 8'hA5);
    push_write(CHIP_LEFT, CMD_DATA, 8'hA5);
    // same cell rewritten with the byte it holds
    push_write(CHIP_LEFT, CMD_INSTR, {SET_PAGE_CODE, 4'h3});
    push_write(CHIP_LEFT, CMD_DATA, 8'hA5);
    push_write(CHIP_RIGHT, CMD_DATA, 8'h01);
    push_write(CHIP_RIGHT, CMD_INSTR, {SET_PAGE_CODE, 4'hB});
    push_write(CHIP_RIGHT, CMD_DATA, 8'h80);
    push_write(CHIP_RIGHT, CMD_DATA, 8'hB5);
    // pages out of range
    push_write(CHIP_RIGHT, CMD_INSTR, {SET_PAGE_CODE, 4'hC});
    push_write(CHIP_RIGHT, CMD_DATA, 8'h55);
    push_write(CHIP_RIGHT, CMD_INSTR, {SET_PAGE_CODE, 4'hF});
    push_write(CHIP_RIGHT, CMD_DATA, 8'hFF);
    // instructions other than page set
    push_write(CHIP_LEFT, CMD_INSTR, 8'hA0);
    push_write(CHIP_LEFT, CMD_INSTR, 8'h00);
    push_write(CHIP_LEFT, CMD_INSTR, 8'hFF);
    push_write(CHIP_RIGHT, CMD_INSTR, 8'h3B);
    push_write(CHIP_LEFT, CMD_DATA, 8'h7E);
    push_write(CHIP_RIGHT, CMD_DATA, 8'h42);
    push_write(CHIP_RIGHT, CMD_INSTR, {SET_PAGE_CODE, 4'h0});
    push_write(CHIP_RIGHT, CMD_DATA, 8'hC3);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    drain();

    // output held off while a data burst keeps coming
    send_idle_pct = 0;
    hold_asked++;
    push_write(CHIP_RIGHT, CMD_INSTR, {SET_PAGE_CODE, 4'h5});
    repeat (40) push_write(CHIP_RIGHT, CMD_DATA, BYTE_W'($urandom_range(255, 1)));
    drain();

    recv_idle_pct = 0;
    push_random(150);
    drain();

    send_idle_pct = IDLE_PCT;
    recv_idle_pct = IDLE_PCT;
    push_random(470);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("dual_lcd_display_ram_writer_tb: done, clean");
    end else begin
      $display("dual_lcd_display_ram_writer_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== dual_lcd_display_ram_writer.f =====
+incdir+hdl
hdl/dlcd_pkg.sv
hdl/dlcd_front.sv
hdl/dlcd_fifo.sv
hdl/dlcd_back.sv
hdl/dual_lcd_display_ram_writer.sv
sim/dual_lcd_display_ram_writer_tb.sv
